FILE: rtl/core/set_assoc_lru_cache_tags_defines.svh
// assertion macros shared by the cache tag checker
`ifndef SET_ASSOC_LRU_CACHE_TAGS_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_TAGS_DEFINES_SVH

// same-cycle implication, off while reset is held
`define SALCT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define SALCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/salct_pkg.sv
package salct_pkg;

    localparam int ADDR_W    = 32;
    localparam int BSL_W     = 4;
    localparam int BSL_MIN   = 2;
    localparam int BSL_MAX   = 8;
    localparam int BSL_RESET = 6;
    // block number width at the smallest block size
    localparam int BLK_W     = ADDR_W - BSL_MIN;

    localparam logic       REQ_READ    = 1'b0;
    localparam logic       REQ_WRITE   = 1'b1;
    localparam logic [1:0] OUT_HIT     = 2'd0;
    localparam logic [1:0] OUT_MISS    = 2'd1;
    localparam logic [1:0] OUT_MISS_WB = 2'd2;

    typedef struct packed {
        logic              req_type;
        logic [ADDR_W-1:0] address;
    } t_req;

    typedef struct packed {
        logic [1:0]        outcome;
        logic              evicted;
        logic [ADDR_W-1:0] victim_address;
    } t_res;

    // clamp a written block size into the supported range
    function automatic logic [BSL_W-1:0] sat_bsl(input logic [BSL_W-1:0] v);
        logic [BSL_W-1:0] r;
        if (v < BSL_W'(BSL_MIN)) begin
            r = BSL_W'(BSL_MIN);
        end else if (v > BSL_W'(BSL_MAX)) begin
            r = BSL_W'(BSL_MAX);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/set_assoc_lru_cache_tags.sv
// channel  | direction | handshake                   | payload
// ---------+-----------+-----------------------------+---------------------------
// request  | in        | start high while busy low   | i_req  (req_type, address)
// result   | out       | o_done, one cycle, no stall | o_res  (outcome, evicted,
//          |           |                             |         victim_address)
// config   | in        | i_cfg_valid && o_cfg_ready  | i_cfg_data (block_size_log2)
//
// one item per cycle sustained while busy is low; o_done follows via stages a, b, c and the result register
// the pipeline is address split, set index, set row read, way compare and lru update
// reset runs a clearing pass over all SETS rows of the state memory, busy high meanwhile
// config writes are taken at any time, ready is tied high
// the result side cannot stall: o_done lasts exactly one cycle per item
module set_assoc_lru_cache_tags #(
    parameter int SETS = 64,
    parameter int WAYS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  salct_pkg::t_req               i_req,
    output logic                          o_done,
    output salct_pkg::t_res               o_res,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [salct_pkg::BSL_W-1:0]   i_cfg_data
);

    localparam int  SW        = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int  AW        = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int  BW        = salct_pkg::BLK_W;
    localparam int  TR_W      = WAYS * BW;
    localparam int  ST_W      = WAYS * (2 + AW);
    localparam bit  SETS_POW2 = ((SETS & (SETS - 1)) == 0);

    // block size register
    logic [salct_pkg::BSL_W-1:0] r_bsl;

    // stage a: accepted item
    logic            r_a_valid;
    salct_pkg::t_req r_a_req;
    logic [BW-1:0]   blk_a;

    // stage b: block number, set index worked out here
    logic            r_b_valid;
    logic            r_b_write;
    logic [BW-1:0]   r_b_blk;
    logic [SW-1:0]   set_b;

    // stage c: set row read back, compare and update
    logic            r_c_valid;
    logic            r_c_write;
    logic [BW-1:0]   r_c_blk;
    logic [SW-1:0]   r_c_set;

    // set row stores; tag store keeps the whole block number of each line
    logic [TR_W-1:0] tag_mem [SETS];
    logic [ST_W-1:0] st_mem  [SETS];
    logic [TR_W-1:0] r_tag_rd;
    logic [ST_W-1:0] r_st_rd;

    // bypass for a row written in the same cycle it is read
    logic            r_fwd;
    logic [TR_W-1:0] r_fwd_tag;
    logic [ST_W-1:0] r_fwd_st;
    logic [TR_W-1:0] row_tag;
    logic [ST_W-1:0] row_st;
    logic [TR_W-1:0] n_tag_row;
    logic [ST_W-1:0] n_st_row;
    salct_pkg::t_res n_res;

    // clearing pass
    logic            r_clr_busy;
    logic [SW-1:0]   r_clr_idx;
    logic [ST_W-1:0] st_reset;

    // result register
    logic            r_done;
    salct_pkg::t_res r_res;

    logic            accept;

    assign accept      = start && !busy;
    assign busy        = r_clr_busy;
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_res       = r_res;

    // block size, clamped on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bsl <= salct_pkg::BSL_W'(salct_pkg::BSL_RESET);
        end else if (i_cfg_valid) begin
            r_bsl <= salct_pkg::sat_bsl(i_cfg_data);
        end
    end

    // pipeline valids and clearing control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid  <= 1'b0;
            r_b_valid  <= 1'b0;
            r_c_valid  <= 1'b0;
            r_done     <= 1'b0;
            r_fwd      <= 1'b0;
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else begin
            r_a_valid <= accept;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_done    <= r_c_valid;
            // the row for set_b is being rewritten by the item now in stage c
            r_fwd     <= r_b_valid && r_c_valid && (set_b == r_c_set);
            if (r_clr_busy) begin
                if (r_clr_idx == SW'(SETS - 1)) begin
                    r_clr_busy <= 1'b0;
                end else begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_req <= i_req;
        end
        if (r_a_valid) begin
            r_b_write <= r_a_req.req_type;
            r_b_blk   <= blk_a;
        end
        if (r_b_valid) begin
            r_c_write <= r_b_write;
            r_c_blk   <= r_b_blk;
            r_c_set   <= set_b;
        end
        if (r_c_valid) begin
            r_fwd_tag <= n_tag_row;
            r_fwd_st  <= n_st_row;
            r_res     <= n_res;
        end
    end

    // block number; block size is never below the minimum, so it fits
    assign blk_a = BW'(r_a_req.address >> r_bsl);

    // set index = block mod SETS
    generate
        if (SETS_POW2) begin : g_mask
            if (SETS == 1) begin : g_one
                assign set_b = '0;
            end else begin : g_low
                assign set_b = r_b_blk[SW-1:0];
            end
        end else begin : g_recip
            // quotient estimate from a reciprocal, low by at most one
            localparam int          RM_W  = SW + 1;
            localparam logic [31:0] RECIP = 32'((64'd1 << 32) / SETS);
            logic [BW+31:0] prod_a;
            logic [BW-1:0]  r_b_q;
            logic [RM_W-1:0] prod_lo;
            logic [RM_W-1:0] rem_est;

            assign prod_a = blk_a * RECIP;

            always_ff @(posedge i_clk) begin
                if (r_a_valid) begin
                    r_b_q <= prod_a[BW+31:32];
                end
            end

            // remainder below twice SETS, so only low bits matter
            assign prod_lo = r_b_q[RM_W-1:0] * RM_W'(SETS);
            assign rem_est = r_b_blk[RM_W-1:0] - prod_lo;
            assign set_b   = (rem_est >= RM_W'(SETS)) ? SW'(rem_est - RM_W'(SETS))
                                                      : SW'(rem_est);
        end
    endgenerate

    // reset image of a state row: not valid, clean, age = way number
    always_comb begin
        st_reset = '0;
        for (int k = 0; k < WAYS; k++) begin
            st_reset[2*WAYS + k*AW +: AW] = AW'(k);
        end
    end

    // tag store, no clearing needed since only valid lines are compared
    always_ff @(posedge i_clk) begin
        if (r_c_valid) begin
            tag_mem[r_c_set] <= n_tag_row;
        end
        r_tag_rd <= tag_mem[set_b];
    end

    // valid, dirty and age store
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            st_mem[r_clr_idx] <= st_reset;
        end else if (r_c_valid) begin
            st_mem[r_c_set] <= n_st_row;
        end
        r_st_rd <= st_mem[set_b];
    end

    assign row_tag = r_fwd ? r_fwd_tag : r_tag_rd;
    assign row_st  = r_fwd ? r_fwd_st  : r_st_rd;

    salct_way_update #(
        .WAYS (WAYS)
    ) u_way_update (
        .i_write   (r_c_write),
        .i_blk     (r_c_blk),
        .i_bsl     (r_bsl),
        .i_tag_row (row_tag),
        .i_st_row  (row_st),
        .o_tag_row (n_tag_row),
        .o_st_row  (n_st_row),
        .o_res     (n_res)
    );

endmodule

FILE: rtl/core/salct_way_update.sv
module salct_way_update #(
    parameter int WAYS = 4
) (
    input  logic                                    i_write,
    input  logic [salct_pkg::BLK_W-1:0]             i_blk,
    input  logic [salct_pkg::BSL_W-1:0]             i_bsl,
    input  logic [WAYS*salct_pkg::BLK_W-1:0]        i_tag_row,
    input  logic [WAYS*(2+((WAYS > 1) ? $clog2(WAYS) : 1))-1:0] i_st_row,
    output logic [WAYS*salct_pkg::BLK_W-1:0]        o_tag_row,
    output logic [WAYS*(2+((WAYS > 1) ? $clog2(WAYS) : 1))-1:0] o_st_row,
    output salct_pkg::t_res                         o_res
);

    localparam int AW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WW = AW;
    localparam int BW = salct_pkg::BLK_W;

    // state row: valid bits, then dirty bits, then ages
    logic [BW-1:0]             tag    [WAYS];
    logic [AW-1:0]             age    [WAYS];
    logic [WAYS-1:0]           valid;
    logic [WAYS-1:0]           dirty;
    logic [WAYS-1:0]           n_valid;
    logic [WAYS-1:0]           n_dirty;
    logic                      hit;
    logic                      inv;
    logic [WW-1:0]             hit_way;
    logic [WW-1:0]             inv_way;
    logic [WW-1:0]             vic_way;
    logic [WW-1:0]             sel_way;
    logic [AW-1:0]             pivot;
    logic [salct_pkg::ADDR_W-1:0] vic_blk;

    always_comb begin
        valid = i_st_row[WAYS-1:0];
        dirty = i_st_row[2*WAYS-1:WAYS];
        for (int k = 0; k < WAYS; k++) begin
            tag[k] = i_tag_row[k*BW +: BW];
            age[k] = i_st_row[2*WAYS + k*AW +: AW];
        end

        hit     = 1'b0;
        hit_way = '0;
        inv     = 1'b0;
        inv_way = '0;
        vic_way = '0;
        for (int k = 0; k < WAYS; k++) begin
            if (!hit && valid[k] && tag[k] == i_blk) begin
                hit     = 1'b1;
                hit_way = WW'(k);
            end
            if (!inv && !valid[k]) begin
                inv     = 1'b1;
                inv_way = WW'(k);
            end
            // ages stay a permutation, so the oldest is the single top age
            if (age[k] == AW'(WAYS - 1)) begin
                vic_way = WW'(k);
            end
        end

        sel_way = hit ? hit_way : (inv ? inv_way : vic_way);
        pivot   = age[sel_way];

        n_valid          = valid;
        n_valid[sel_way] = 1'b1;
        n_dirty          = dirty;
        if (hit) begin
            n_dirty[sel_way] = dirty[sel_way] | (i_write == salct_pkg::REQ_WRITE);
        end else begin
            n_dirty[sel_way] = (i_write == salct_pkg::REQ_WRITE);
        end

        o_st_row = {{(WAYS*AW){1'b0}}, n_dirty, n_valid};
        o_tag_row = i_tag_row;
        for (int k = 0; k < WAYS; k++) begin
            if (WW'(k) == sel_way) begin
                o_st_row[2*WAYS + k*AW +: AW] = '0;
                if (!hit) begin
                    o_tag_row[k*BW +: BW] = i_blk;
                end
            end else if (age[k] < pivot) begin
                o_st_row[2*WAYS + k*AW +: AW] = age[k] + 1'b1;
            end else begin
                o_st_row[2*WAYS + k*AW +: AW] = age[k];
            end
        end

        vic_blk = salct_pkg::ADDR_W'(tag[vic_way]);
        if (hit) begin
            o_res.outcome        = salct_pkg::OUT_HIT;
            o_res.evicted        = 1'b0;
            o_res.victim_address = '0;
        end else if (inv) begin
            o_res.outcome        = salct_pkg::OUT_MISS;
            o_res.evicted        = 1'b0;
            o_res.victim_address = '0;
        end else begin
            o_res.outcome        = dirty[vic_way] ? salct_pkg::OUT_MISS_WB
                                                  : salct_pkg::OUT_MISS;
            o_res.evicted        = 1'b1;
            o_res.victim_address = vic_blk << i_bsl;
        end
    end

endmodule

FILE: rtl/core/salct_checker.sv
`include "set_assoc_lru_cache_tags_defines.svh"

module salct_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            start,
    input logic            busy,
    input logic            o_done,
    input salct_pkg::t_res o_res
);

    logic take;
    logic quiet_res;
    logic vic_clear;

    assign take      = start && !busy;
    assign quiet_res = o_done && (!o_res.evicted || o_res.outcome == salct_pkg::OUT_HIT);
    assign vic_clear = !o_res.evicted && (o_res.victim_address == '0);

    // every taken item gives its result once it has passed stages a, b, c and the result register
    `SALCT_ASSERT_NOW(a_item_done, i_clk, i_rst_n, take, ##4 o_done, "item without result")

    // no result appears without an item taken at the head of the pipeline
    `SALCT_ASSERT_NOW(a_done_item, i_clk, i_rst_n, o_done, $past(take, 4), "spurious result")

    // busy only comes from the clearing pass after reset
    `SALCT_ASSERT_NEXT(a_busy_once, i_clk, i_rst_n, !busy, !busy, "busy raised outside reset")

    // a result with no eviction carries a zero victim address, a hit never evicts
    `SALCT_ASSERT_NOW(a_victim, i_clk, i_rst_n, quiet_res, vic_clear, "bad victim report")

endmodule

bind set_assoc_lru_cache_tags salct_checker u_salct_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_res   (o_res)
);
